// File: hdl/bta_pkg.sv
// Shared types, constants and helpers for the boundary tag allocator.
// No dependencies; bta_front, bta_back and the core import this package.
`timescale 1ns / 1ps
`default_nettype none

package bta_pkg;

  localparam int HEAP_UNITS = 4096;
  localparam int UNIT_BYTES = 16;
  localparam int UNIT_SHIFT = $clog2(UNIT_BYTES);
  localparam int IDX_W      = $clog2(HEAP_UNITS);
  localparam int SIZE_W     = IDX_W + 1;
  localparam int TAG_W      = SIZE_W + 1;
  localparam int PAGE_W     = 13;
  localparam int MIN_BLK    = 4;
  localparam int STEP_LIMIT = 4 * HEAP_UNITS + 16;
  localparam int STEP_W     = $clog2(STEP_LIMIT + 1);
  localparam int WSTEP_W    = $clog2(HEAP_UNITS + 2);
  localparam int PAGE_RESET = 256;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_RESIZE = 2'd2,
    OP_INIT   = 2'd3
  } bta_op_e;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_OOM = 2'd1,
    ST_BAD = 2'd2
  } bta_status_e;

  typedef enum logic [2:0] {
    K_ALLOC     = 3'd0,
    K_FREE      = 3'd1,
    K_FREE_NULL = 3'd2,
    K_RESIZE    = 3'd3,
    K_INIT      = 3'd4
  } bta_kind_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] addr;
    logic        addr_is_null;
    logic [15:0] nbytes;
  } bta_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] result_addr;
    logic        result_is_null;
    logic [15:0] copy_from;
    logic [15:0] copy_bytes;
  } bta_rsp_t;

  // Classified command handed from the front queue to the sequencer
  typedef struct packed {
    bta_kind_e         kind;
    logic [SIZE_W-1:0] units;
    logic [15:0]       addr;
  } bta_cmd_t;

  function automatic logic [TAG_W-1:0] mk_tag(input logic [SIZE_W-1:0] size, input logic alloc);
    return {size, alloc};
  endfunction

  function automatic logic [15:0] payload_addr(input logic [IDX_W-1:0] hdr);
    logic [IDX_W+UNIT_SHIFT:0] p;
    p = (IDX_W+UNIT_SHIFT+1)'(hdr) + (IDX_W+UNIT_SHIFT+1)'(1);
    p = p << UNIT_SHIFT;
    return p[15:0];
  endfunction

endpackage

`default_nettype wire

// File: hdl/bta_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bta_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

// File: hdl/bta_front.sv
// Front end: accepts requests, classifies them and queues them (two entries).
// Depends on bta_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bta_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire bta_pkg::bta_req_t req_i,
  output logic                   cmd_valid_o,
  output bta_pkg::bta_cmd_t      cmd_o,
  input  wire logic              cmd_pop_i
);
  import bta_pkg::*;

  logic [1:0]        cnt_q, cnt_d;
  logic              wptr_q, rptr_q;
  bta_cmd_t          ent_q [2];
  bta_cmd_t          cls;
  logic              push;
  logic [SIZE_W-1:0] req_units;

  assign busy        = (cnt_q == 2'd2);
  assign push        = start && !busy;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = ent_q[rptr_q];

  // Units = ceil(nbytes / unit) plus header and footer
  assign req_units = SIZE_W'(req_i.nbytes[15:UNIT_SHIFT]) +
                     SIZE_W'(|req_i.nbytes[UNIT_SHIFT-1:0]) + SIZE_W'(2);

  always_comb begin
    cls.addr  = req_i.addr;
    cls.units = req_units;
    cls.kind  = K_ALLOC;
    unique case (bta_op_e'(req_i.op))
      OP_ALLOC: cls.kind = K_ALLOC;
      OP_FREE:  cls.kind = req_i.addr_is_null ? K_FREE_NULL : K_FREE;
      OP_RESIZE: cls.kind = req_i.addr_is_null ? K_ALLOC : K_RESIZE;
      OP_INIT:  cls.kind = K_INIT;
      default:  cls.kind = K_INIT;
    endcase
    if (cls.kind == K_ALLOC && req_units < SIZE_W'(MIN_BLK)) begin
      cls.units = SIZE_W'(MIN_BLK);
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push && !cmd_pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && cmd_pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 2'd0;
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wptr_q <= ~wptr_q;
      end
      if (cmd_pop_i) begin
        rptr_q <= ~rptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wptr_q] <= cls;
    end
  end

endmodule

`default_nettype wire

// File: hdl/bta_back.sv
// Back end: sequencer that carries out queued commands on the tag store.
// Depends on bta_pkg and bta_ram.
`timescale 1ns / 1ps
`default_nettype none

module bta_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cmd_valid_i,
  input  wire bta_pkg::bta_cmd_t           cmd_i,
  output logic                             cmd_pop_o,
  input  wire logic [bta_pkg::PAGE_W-1:0]  page_i,
  output logic                             result_valid_o,
  output bta_pkg::bta_rsp_t                rsp_o
);
  import bta_pkg::*;

  localparam int NS = 47;

  typedef enum logic [NS-1:0] {
    S_IDLE  = NS'(1) << 0,  S_INIT  = NS'(1) << 1,  S_RCHK  = NS'(1) << 2,
    S_RFAST = NS'(1) << 3,  S_RFOOT = NS'(1) << 4,  S_RWALK = NS'(1) << 5,
    S_RDONE = NS'(1) << 6,  S_TRD   = NS'(1) << 7,  S_TTAG  = NS'(1) << 8,
    S_TNEXT = NS'(1) << 9,  S_TWPV  = NS'(1) << 10, S_TWNX  = NS'(1) << 11,
    S_TWU   = NS'(1) << 12, S_TWH   = NS'(1) << 13, S_TWF   = NS'(1) << 14,
    S_TWF2  = NS'(1) << 15, S_TS1   = NS'(1) << 16, S_TS2   = NS'(1) << 17,
    S_TS3   = NS'(1) << 18, S_TS4   = NS'(1) << 19, S_TOK   = NS'(1) << 20,
    S_GROW  = NS'(1) << 21, S_G1    = NS'(1) << 22, S_G2    = NS'(1) << 23,
    S_G3    = NS'(1) << 24, S_LRD   = NS'(1) << 25, S_LHDR  = NS'(1) << 26,
    S_LFRD  = NS'(1) << 27, S_LFWR  = NS'(1) << 28, S_LPRD  = NS'(1) << 29,
    S_LPREV = NS'(1) << 30, S_LCRD  = NS'(1) << 31, S_LCHDR = NS'(1) << 32,
    S_LCFTR = NS'(1) << 33, S_LA1   = NS'(1) << 34, S_LA2   = NS'(1) << 35,
    S_LA3   = NS'(1) << 36, S_LA4   = NS'(1) << 37, S_LNRD  = NS'(1) << 38,
    S_LNXT  = NS'(1) << 39, S_LUNX  = NS'(1) << 40, S_LUPV  = NS'(1) << 41,
    S_LUW   = NS'(1) << 42, S_LSRD  = NS'(1) << 43, S_LSHDR = NS'(1) << 44,
    S_LSFTR = NS'(1) << 45, S_DONE  = NS'(1) << 46
  } bta_state_e;

  bta_state_e state_q, state_d;
  logic [2:0] icnt_q, icnt_d;
  logic       boot_q, boot_d;
  logic [IDX_W-1:0]  fh_q, fh_d;
  logic [SIZE_W-1:0] he_q, he_d;

  bta_cmd_t          cmd_q, cmd_d;
  bta_rsp_t          res_q, res_d;
  logic [IDX_W-1:0]  tb_q, tb_d, pv_q, pv_d, nx_q, nx_d, rb_q, rb_d;
  logic [IDX_W-1:0]  wb_q, wb_d, ob_q, ob_d;
  logic [SIZE_W-1:0] tn_q, tn_d, ts_q, ts_d, rn_q, rn_d, gg_q, gg_d, cur_q, cur_d;
  logic [STEP_W-1:0]  steps_q, steps_d;
  logic [WSTEP_W-1:0] wsteps_q, wsteps_d;
  logic [TAG_W-1:0]   rtag_q, rtag_d;
  logic               rel_grow_q, rel_grow_d;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_addr;
  logic [TAG_W-1:0]  ram_wdata, ram_rdata;

  bta_ram #(
    .WIDTH (TAG_W),
    .DEPTH (HEAP_UNITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign result_valid_o = (state_q == S_DONE);
  assign rsp_o          = res_q;

  always_comb begin
    logic [SIZE_W-1:0]       sz, off, g, room, gc, nn;
    logic [IDX_W-1:0]        u, c, rc;
    logic [IDX_W+UNIT_SHIFT:0] hi;
    logic                    bad;

    state_d    = state_q;
    icnt_d     = icnt_q;
    boot_d     = boot_q;
    fh_d       = fh_q;
    he_d       = he_q;
    cmd_d      = cmd_q;
    res_d      = res_q;
    tb_d       = tb_q;
    pv_d       = pv_q;
    nx_d       = nx_q;
    rb_d       = rb_q;
    wb_d       = wb_q;
    ob_d       = ob_q;
    tn_d       = tn_q;
    ts_d       = ts_q;
    rn_d       = rn_q;
    gg_d       = gg_q;
    cur_d      = cur_q;
    steps_d    = steps_q;
    wsteps_d   = wsteps_q;
    rtag_d     = rtag_q;
    rel_grow_d = rel_grow_q;
    cmd_pop_o  = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = tb_q;
    ram_wdata  = '0;

    sz   = ram_rdata[TAG_W-1:1];
    off  = ts_q - tn_q;
    u    = cmd_q.addr[IDX_W+UNIT_SHIFT-1:UNIT_SHIFT];
    c    = u - IDX_W'(1);
    rc   = IDX_W'(SIZE_W'(rb_q) + rn_q);
    hi   = ((IDX_W+UNIT_SHIFT+1)'(he_q) << UNIT_SHIFT) - (IDX_W+UNIT_SHIFT+1)'(1);
    bad  = (cmd_q.addr == 16'd0) || ((IDX_W+UNIT_SHIFT+1)'(cmd_q.addr) >= hi);
    g    = (tn_q < page_i) ? page_i : tn_q;
    room = SIZE_W'(HEAP_UNITS) - he_q;
    gc   = (g > room) ? room : g;
    nn   = rn_q + sz;

    unique case (state_q)
      S_INIT: begin
        ram_we = 1'b1;
        icnt_d = icnt_q + 3'd1;
        unique case (icnt_q)
          3'd0: begin
            ram_addr  = IDX_W'(0);
            ram_wdata = mk_tag(SIZE_W'(MIN_BLK), 1'b1);
          end
          3'd1: begin
            ram_addr  = IDX_W'(MIN_BLK - 1);
            ram_wdata = mk_tag(SIZE_W'(MIN_BLK), 1'b1);
          end
          3'd2: ram_addr = IDX_W'(1);
          3'd3: ram_addr = IDX_W'(2);
          default: begin
            ram_addr  = IDX_W'(MIN_BLK);
            ram_wdata = mk_tag(SIZE_W'(1), 1'b1);
          end
        endcase
        if (icnt_q >= 3'd4) begin
          fh_d = '0;
          he_d = SIZE_W'(MIN_BLK + 1);
          res_d = '{status: ST_OK, result_addr: 16'd0, result_is_null: 1'b1,
                    copy_from: 16'd0, copy_bytes: 16'd0};
          boot_d  = 1'b0;
          state_d = boot_q ? S_IDLE : S_DONE;
        end
      end

      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          res_d = '{status: ST_OK, result_addr: 16'd0, result_is_null: 1'b1,
                    copy_from: 16'd0, copy_bytes: 16'd0};
          unique case (cmd_i.kind)
            K_INIT: begin
              icnt_d  = 3'd0;
              state_d = S_INIT;
            end
            K_FREE_NULL: state_d = S_DONE;
            K_ALLOC: begin
              tn_d    = cmd_i.units;
              tb_d    = fh_q;
              steps_d = '0;
              state_d = S_TRD;
            end
            K_FREE, K_RESIZE: state_d = S_RCHK;
            default: state_d = S_DONE;
          endcase
        end
      end

      // Pointer resolution
      S_RCHK: begin
        wb_d     = '0;
        wsteps_d = '0;
        if (bad) begin
          res_d.status = ST_BAD;
          state_d      = S_DONE;
        end else if (cmd_q.addr[UNIT_SHIFT-1:0] == '0) begin
          ram_addr = c;
          state_d  = S_RFAST;
        end else begin
          ram_addr = '0;
          state_d  = S_RWALK;
        end
      end

      S_RFAST: begin
        if (ram_rdata[0] && sz >= SIZE_W'(MIN_BLK) &&
            (SIZE_W+1)'(c) + (SIZE_W+1)'(sz) < (SIZE_W+1)'(he_q)) begin
          rtag_d   = ram_rdata;
          ram_addr = IDX_W'(SIZE_W'(c) + sz - SIZE_W'(1));
          state_d  = S_RFOOT;
        end else begin
          ram_addr = '0;
          state_d  = S_RWALK;
        end
      end

      S_RFOOT: begin
        if (ram_rdata == rtag_q) begin
          wb_d    = c;
          state_d = S_RDONE;
        end else begin
          ram_addr = '0;
          state_d  = S_RWALK;
        end
      end

      S_RWALK: begin
        if (sz == '0 || wsteps_q > WSTEP_W'(HEAP_UNITS)) begin
          res_d.status = ST_BAD;
          state_d      = S_DONE;
        end else begin
          wsteps_d = wsteps_q + WSTEP_W'(1);
          if ((SIZE_W+1)'(wb_q) + (SIZE_W+1)'(sz) > (SIZE_W+1)'(u)) begin
            rtag_d  = ram_rdata;
            state_d = S_RDONE;
          end else begin
            wb_d     = IDX_W'(SIZE_W'(wb_q) + sz);
            ram_addr = IDX_W'(SIZE_W'(wb_q) + sz);
          end
        end
      end

      S_RDONE: begin
        if (!rtag_q[0] || wb_q == '0 || rtag_q[TAG_W-1:1] < SIZE_W'(MIN_BLK) ||
            (SIZE_W+1)'(wb_q) + (SIZE_W+1)'(rtag_q[TAG_W-1:1]) >= (SIZE_W+1)'(he_q)) begin
          res_d.status = ST_BAD;
          state_d      = S_DONE;
        end else if (cmd_q.kind == K_FREE) begin
          rb_d       = wb_q;
          rel_grow_d = 1'b0;
          state_d    = S_LRD;
        end else begin
          ob_d  = wb_q;
          cur_d = rtag_q[TAG_W-1:1];
          if (cmd_q.units <= rtag_q[TAG_W-1:1]) begin
            res_d.result_addr    = cmd_q.addr;
            res_d.result_is_null = 1'b0;
            state_d              = S_DONE;
          end else begin
            tn_d    = cmd_q.units;
            tb_d    = fh_q;
            steps_d = '0;
            state_d = S_TRD;
          end
        end
      end

      // First-fit search of the free list
      S_TRD: begin
        ram_addr = tb_q;
        if (steps_q >= STEP_W'(STEP_LIMIT)) begin
          res_d.status = ST_OOM;
          state_d      = S_DONE;
        end else begin
          steps_d = steps_q + STEP_W'(1);
          state_d = S_TTAG;
        end
      end

      S_TTAG: begin
        if (!ram_rdata[0] && sz >= tn_q) begin
          ts_d = sz;
          if ((SIZE_W+1)'(sz) < (SIZE_W+1)'(tn_q) + (SIZE_W+1)'(MIN_BLK)) begin
            ram_addr = tb_q + IDX_W'(1);
            state_d  = S_TWPV;
          end else begin
            state_d = S_TS1;
          end
        end else begin
          ram_addr = tb_q + IDX_W'(2);
          state_d  = S_TNEXT;
        end
      end

      S_TNEXT: begin
        tb_d    = ram_rdata[IDX_W-1:0];
        state_d = (ram_rdata[IDX_W-1:0] == fh_q) ? S_GROW : S_TRD;
      end

      // Whole block taken: unlink it
      S_TWPV: begin
        pv_d = ram_rdata[IDX_W-1:0];
        if (fh_q == tb_q) begin
          fh_d = ram_rdata[IDX_W-1:0];
        end
        ram_addr = tb_q + IDX_W'(2);
        state_d  = S_TWNX;
      end

      S_TWNX: begin
        nx_d      = ram_rdata[IDX_W-1:0];
        ram_we    = 1'b1;
        ram_addr  = pv_q + IDX_W'(2);
        ram_wdata = TAG_W'(ram_rdata[IDX_W-1:0]);
        state_d   = S_TWU;
      end

      S_TWU: begin
        ram_we    = 1'b1;
        ram_addr  = nx_q + IDX_W'(1);
        ram_wdata = TAG_W'(pv_q);
        state_d   = S_TWH;
      end

      S_TWH: begin
        ram_we    = 1'b1;
        ram_addr  = tb_q;
        ram_wdata = mk_tag(ts_q, 1'b1);
        state_d   = S_TWF;
      end

      S_TWF: begin
        ram_addr = IDX_W'(SIZE_W'(tb_q) + ts_q - SIZE_W'(1));
        state_d  = S_TWF2;
      end

      S_TWF2: begin
        ram_we    = 1'b1;
        ram_addr  = IDX_W'(SIZE_W'(tb_q) + ts_q - SIZE_W'(1));
        ram_wdata = mk_tag(sz, 1'b1);
        state_d   = S_TOK;
      end

      // Split: keep the front free, hand out the tail
      S_TS1: begin
        ram_we    = 1'b1;
        ram_addr  = tb_q;
        ram_wdata = mk_tag(off, 1'b0);
        state_d   = S_TS2;
      end

      S_TS2: begin
        ram_we    = 1'b1;
        ram_addr  = IDX_W'(SIZE_W'(tb_q) + off - SIZE_W'(1));
        ram_wdata = mk_tag(off, 1'b0);
        state_d   = S_TS3;
      end

      S_TS3: begin
        ram_we    = 1'b1;
        ram_addr  = IDX_W'(SIZE_W'(tb_q) + off);
        ram_wdata = mk_tag(tn_q, 1'b1);
        tb_d      = IDX_W'(SIZE_W'(tb_q) + off);
        state_d   = S_TS4;
      end

      S_TS4: begin
        ram_we    = 1'b1;
        ram_addr  = IDX_W'(SIZE_W'(tb_q) + tn_q - SIZE_W'(1));
        ram_wdata = mk_tag(tn_q, 1'b1);
        state_d   = S_TOK;
      end

      S_TOK: begin
        res_d.result_addr    = payload_addr(tb_q);
        res_d.result_is_null = 1'b0;
        if (cmd_q.kind == K_RESIZE) begin
          res_d.copy_from  = payload_addr(ob_q);
          res_d.copy_bytes = 16'(32'(cur_q - SIZE_W'(2)) << UNIT_SHIFT);
          rb_d             = ob_q;
          rel_grow_d       = 1'b0;
          state_d          = S_LRD;
        end else begin
          state_d = S_DONE;
        end
      end

      // Heap growth over the old epilogue
      S_GROW: begin
        if (gc < tn_q) begin
          res_d.status = ST_OOM;
          state_d      = S_DONE;
        end else begin
          gg_d    = gc;
          rb_d    = IDX_W'(he_q - SIZE_W'(1));
          state_d = S_G1;
        end
      end

      S_G1: begin
        ram_we    = 1'b1;
        ram_addr  = rb_q;
        ram_wdata = mk_tag(gg_q, 1'b0);
        state_d   = S_G2;
      end

      S_G2: begin
        ram_we    = 1'b1;
        ram_addr  = IDX_W'(SIZE_W'(rb_q) + gg_q - SIZE_W'(1));
        ram_wdata = mk_tag(gg_q, 1'b0);
        state_d   = S_G3;
      end

      S_G3: begin
        ram_we     = 1'b1;
        ram_addr   = IDX_W'(SIZE_W'(rb_q) + gg_q);
        ram_wdata  = mk_tag(SIZE_W'(1), 1'b1);
        he_d       = he_q + gg_q;
        rel_grow_d = 1'b1;
        state_d    = S_LRD;
      end

      // Release with coalescing
      S_LRD: begin
        ram_addr = rb_q;
        state_d  = S_LHDR;
      end

      S_LHDR: begin
        rn_d      = sz;
        ram_we    = 1'b1;
        ram_addr  = rb_q;
        ram_wdata = mk_tag(sz, 1'b0);
        state_d   = S_LFRD;
      end

      S_LFRD: begin
        ram_addr = IDX_W'(SIZE_W'(rb_q) + rn_q - SIZE_W'(1));
        state_d  = S_LFWR;
      end

      S_LFWR: begin
        ram_we    = 1'b1;
        ram_addr  = IDX_W'(SIZE_W'(rb_q) + rn_q - SIZE_W'(1));
        ram_wdata = mk_tag(sz, 1'b0);
        state_d   = S_LPRD;
      end

      S_LPRD: begin
        ram_addr = rb_q - IDX_W'(1);
        state_d  = S_LPREV;
      end

      S_LPREV: begin
        if (!ram_rdata[0]) begin
          rb_d    = IDX_W'(SIZE_W'(rb_q) - sz);
          state_d = S_LCRD;
        end else begin
          ram_addr = fh_q + IDX_W'(2);
          state_d  = S_LA1;
        end
      end

      S_LCRD: begin
        ram_addr = rb_q;
        state_d  = S_LCHDR;
      end

      S_LCHDR: begin
        rn_d      = nn;
        ram_we    = 1'b1;
        ram_addr  = rb_q;
        ram_wdata = mk_tag(nn, 1'b0);
        state_d   = S_LCFTR;
      end

      S_LCFTR: begin
        ram_we    = 1'b1;
        ram_addr  = IDX_W'(SIZE_W'(rb_q) + rn_q - SIZE_W'(1));
        ram_wdata = mk_tag(rn_q, 1'b0);
        state_d   = S_LNRD;
      end

      // Link after the current list head
      S_LA1: begin
        nx_d      = ram_rdata[IDX_W-1:0];
        ram_we    = 1'b1;
        ram_addr  = rb_q + IDX_W'(1);
        ram_wdata = TAG_W'(fh_q);
        state_d   = S_LA2;
      end

      S_LA2: begin
        ram_we    = 1'b1;
        ram_addr  = rb_q + IDX_W'(2);
        ram_wdata = TAG_W'(nx_q);
        state_d   = S_LA3;
      end

      S_LA3: begin
        ram_we    = 1'b1;
        ram_addr  = fh_q + IDX_W'(2);
        ram_wdata = TAG_W'(rb_q);
        state_d   = S_LA4;
      end

      S_LA4: begin
        ram_we    = 1'b1;
        ram_addr  = nx_q + IDX_W'(1);
        ram_wdata = TAG_W'(rb_q);
        state_d   = S_LNRD;
      end

      S_LNRD: begin
        fh_d     = rb_q;
        ram_addr = rc;
        state_d  = S_LNXT;
      end

      S_LNXT: begin
        if (!ram_rdata[0]) begin
          ram_addr = rc + IDX_W'(2);
          state_d  = S_LUNX;
        end else if (rel_grow_q) begin
          tb_d    = rb_q;
          state_d = S_TRD;
        end else begin
          state_d = S_DONE;
        end
      end

      // Unlink the free successor before merging it
      S_LUNX: begin
        nx_d     = ram_rdata[IDX_W-1:0];
        ram_addr = rc + IDX_W'(1);
        state_d  = S_LUPV;
      end

      S_LUPV: begin
        pv_d      = ram_rdata[IDX_W-1:0];
        ram_we    = 1'b1;
        ram_addr  = ram_rdata[IDX_W-1:0] + IDX_W'(2);
        ram_wdata = TAG_W'(nx_q);
        state_d   = S_LUW;
      end

      S_LUW: begin
        ram_we    = 1'b1;
        ram_addr  = nx_q + IDX_W'(1);
        ram_wdata = TAG_W'(pv_q);
        state_d   = S_LSRD;
      end

      S_LSRD: begin
        ram_addr = rc;
        state_d  = S_LSHDR;
      end

      S_LSHDR: begin
        rn_d      = nn;
        ram_we    = 1'b1;
        ram_addr  = rb_q;
        ram_wdata = mk_tag(nn, 1'b0);
        state_d   = S_LSFTR;
      end

      S_LSFTR: begin
        ram_we    = 1'b1;
        ram_addr  = IDX_W'(SIZE_W'(rb_q) + rn_q - SIZE_W'(1));
        ram_wdata = mk_tag(rn_q, 1'b0);
        if (rel_grow_q) begin
          tb_d    = rb_q;
          state_d = S_TRD;
        end else begin
          state_d = S_DONE;
        end
      end

      S_DONE: state_d = S_IDLE;

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      icnt_q  <= 3'd0;
      boot_q  <= 1'b1;
      fh_q    <= '0;
      he_q    <= SIZE_W'(MIN_BLK + 1);
    end else begin
      state_q <= state_d;
      icnt_q  <= icnt_d;
      boot_q  <= boot_d;
      fh_q    <= fh_d;
      he_q    <= he_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    res_q      <= res_d;
    tb_q       <= tb_d;
    pv_q       <= pv_d;
    nx_q       <= nx_d;
    rb_q       <= rb_d;
    wb_q       <= wb_d;
    ob_q       <= ob_d;
    tn_q       <= tn_d;
    ts_q       <= ts_d;
    rn_q       <= rn_d;
    gg_q       <= gg_d;
    cur_q      <= cur_d;
    steps_q    <= steps_d;
    wsteps_q   <= wsteps_d;
    rtag_q     <= rtag_d;
    rel_grow_q <= rel_grow_d;
  end

endmodule

`default_nettype wire

// File: hdl/boundary_tag_free_list_allocator_core.sv
// Latency varies with heap contents: a request is queued first, then the sequencer spends
// time per free-list node searched, per block walked when a pointer is resolved by walking,
// and on each release; a free of null goes straight to the result.
// One command runs at a time in the sequencer, bound by the single tag store port.
// After reset the sequencer writes the dummy and epilogue tags; requests are
// queued meanwhile. Results appear as a one-cycle strobe; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module boundary_tag_free_list_allocator_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire bta_pkg::bta_req_t          req_i,
  output logic                            result_valid_o,
  output bta_pkg::bta_rsp_t               rsp_o,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [bta_pkg::PAGE_W-1:0] cfg_data_i
);
  import bta_pkg::*;

  logic              cmd_valid;
  logic              cmd_pop;
  bta_cmd_t          cmd;
  logic [PAGE_W-1:0] page_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q <= PAGE_W'(PAGE_RESET);
    end else if (cfg_valid_i && cfg_ready_o) begin
      page_q <= cfg_data_i;
    end
  end

  bta_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  bta_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .cmd_pop_o      (cmd_pop),
    .page_i         (page_q),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o)
  );

`ifndef SYNTHESIS
  a_null_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && rsp_o.result_is_null |-> rsp_o.result_addr == 16'd0)
    else $error("null result carries an address");

  a_fail_is_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && rsp_o.status != ST_OK |->
      rsp_o.result_is_null && rsp_o.copy_bytes == 16'd0)
    else $error("failed transaction returns a pointer or copy");

  a_copy_has_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && rsp_o.copy_bytes != 16'd0 |->
      rsp_o.copy_from != 16'd0 && !rsp_o.result_is_null)
    else $error("copy without source or destination");

  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("sequencer popped an empty queue");
`endif

endmodule

`default_nettype wire
